/* hdl/dwlw_pkg.sv */
// Shared types, constants and the code unit width lookup for the line wrapper.
package dwlw_pkg;

   localparam int UNIT_W   = 16;
   localparam int WRAP_W   = 10;
   localparam int TAB_W    = 7;
   localparam int COL_W    = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 10;
   localparam int STEP_W   = 4;   // one remainder step per column bit

   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_COLUMNS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAB_COLUMNS  = 1'b1;

   localparam logic [WRAP_W-1:0] WRAP_RESET = 10'd80;
   localparam logic [TAB_W-1:0]  TAB_RESET  = 7'd4;
   localparam logic [TAB_W-1:0]  TAB_DEFAULT = 7'd4;

   localparam logic [UNIT_W-1:0] CODE_TAB = 16'h0009;
   localparam logic [STEP_W-1:0] STEP_LAST = 4'd15;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REM,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic rem_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic tab_in;
      logic rem_done;
   } status_type;

   // Width of a unit that is not a tab and not a paired lead surrogate.
   function automatic logic [1:0] base_width(input logic [UNIT_W-1:0] u);
      logic wide;
      wide = ((u >= 16'h1100) && (u <= 16'h115F)) ||
             ((u >= 16'h2E80) && (u <= 16'hA4CF)) ||
             ((u >= 16'hAC00) && (u <= 16'hD7A3)) ||
             ((u >= 16'hF900) && (u <= 16'hFAFF)) ||
             ((u >= 16'hFF00) && (u <= 16'hFF60)) ||
             ((u >= 16'hFFE0) && (u <= 16'hFFE6)) ||
             ((u >= 16'hD800) && (u <= 16'hDFFF));
      if ((u >= 16'hFF61) && (u <= 16'hFF9F)) begin
         return 2'd1;
      end
      return wide ? 2'd2 : 2'd1;
   endfunction

   function automatic logic is_lead(input logic [UNIT_W-1:0] u);
      return (u >= 16'hD800) && (u <= 16'hDBFF);
   endfunction

endpackage

/* hdl/dwlw_ctrl.sv */
// Sequencer: input transfer, tab remainder steps, result commit, output register valid.
module dwlw_ctrl import dwlw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.tab_in ? ST_REM : ST_FINISH;
            end
         end
         ST_REM: begin
            cmd.rem_step = 1'b1;
            if (status.rem_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register can take the result
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/dwlw_dp.sv */
// Datapath: config registers, column state, tab remainder unit, width logic, result register.
module dwlw_dp import dwlw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [UNIT_W-1:0]     req_code_unit,
   input  logic                  req_last_unit,
   input  cmd_type               cmd,
   output status_type            status,
   output logic                  rsp_break_before,
   output logic [TAB_W-1:0]      rsp_unit_width,
   output logic [COL_W-1:0]      rsp_column_after,
   output logic                  rsp_line_end
);

   logic [WRAP_W-1:0] wrap_ff;
   logic [TAB_W-1:0]  tab_ff;
   logic [COL_W-1:0]  column_ff, column_in;
   logic              skip_ff, skip_in;
   logic [UNIT_W-1:0] unit_ff;
   logic              last_ff;
   logic [TAB_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff;

   logic [TAB_W-1:0]  tab_eff;
   logic [TAB_W:0]    rem_trial;
   logic              unit_tab, pair_lead;
   logic [TAB_W-1:0]  width;
   logic [COL_W:0]    col_sum, col_trial;
   logic              brk;
   logic [COL_W-1:0]  col_after;

   assign tab_eff = (tab_ff == '0) ? TAB_DEFAULT : tab_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff <= WRAP_RESET;
         tab_ff  <= TAB_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WRAP_COLUMNS: wrap_ff <= csr_wdata[WRAP_W-1:0];
            CSR_TAB_COLUMNS:  tab_ff  <= csr_wdata[TAB_W-1:0];
            default: ;
         endcase
      end
   end

   // restoring remainder of the column by the tab spacing, MSB first
   always_comb begin
      rem_trial = {rem_ff, column_ff[STEP_LAST - step_ff]};
      if (rem_trial >= {1'b0, tab_eff}) begin
         rem_trial = rem_trial - {1'b0, tab_eff};
      end
      rem_in = rem_trial[TAB_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         unit_ff <= req_code_unit;
         last_ff <= req_last_unit;
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.rem_step) begin
         rem_ff  <= rem_in;
         step_ff <= step_ff + 1'b1;
      end
   end

   assign status.tab_in   = (req_code_unit == CODE_TAB) && !skip_ff;
   assign status.rem_done = (step_ff == STEP_LAST);

   always_comb begin
      unit_tab  = (unit_ff == CODE_TAB);
      pair_lead = is_lead(unit_ff) && !last_ff;
      if (skip_ff) begin
         width = '0;
      end else if (unit_tab) begin
         width = tab_eff - rem_ff;
      end else if (pair_lead) begin
         width = 7'd2;
      end else begin
         width = {5'd0, base_width(unit_ff)};
      end
      col_trial = {1'b0, column_ff} + {10'd0, width};
      brk = !skip_ff && (wrap_ff != '0) && (column_ff != '0) &&
            (col_trial > {7'd0, wrap_ff});
      col_sum   = brk ? {10'd0, width} : col_trial;
      col_after = col_sum[COL_W] ? {COL_W{1'b1}} : col_sum[COL_W-1:0];
      skip_in   = !skip_ff && !unit_tab && pair_lead;
      // drop line state at the end of the line
      column_in = last_ff ? '0 : col_after;
      if (last_ff) begin
         skip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         skip_ff   <= 1'b0;
      end else if (cmd.commit) begin
         column_ff <= column_in;
         skip_ff   <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_break_before <= brk;
         rsp_unit_width   <= width;
         rsp_column_after <= col_after;
         rsp_line_end     <= last_ff;
      end
   end

endmodule

/* hdl/display_width_line_wrapper.sv */
// Top level of the display width line wrapper.
//
//  channel   ports                                         direction
//  req       req_valid/ready, code_unit, last_unit         in
//  rsp       rsp_valid/ready, break_before, unit_width,    out
//            column_after, line_end
//  csr       csr_write, csr_index, csr_wdata               in (write only)
//
// A unit passes the transfer cycle, then the cycle that loads the result register,
// which waits while the output register is still held. A tab runs the bit-serial
// column-by-tab-spacing remainder between the two.
// One unit is in work at a time; the next is taken as soon as the previous
// result is registered, even while that result is stalled at rsp.
// Synchronous reset restores wrap 80, tab 4, column 0, no pending trail unit.
module display_width_line_wrapper import dwlw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [UNIT_W-1:0]     req_code_unit,
   input  logic                  req_last_unit,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_break_before,
   output logic [TAB_W-1:0]      rsp_unit_width,
   output logic [COL_W-1:0]      rsp_column_after,
   output logic                  rsp_line_end,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   dwlw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dwlw_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_code_unit    (req_code_unit),
      .req_last_unit    (req_last_unit),
      .cmd              (cmd),
      .status           (status),
      .rsp_break_before (rsp_break_before),
      .rsp_unit_width   (rsp_unit_width),
      .rsp_column_after (rsp_column_after),
      .rsp_line_end     (rsp_line_end)
   );

endmodule

/* hdl/dwlw_checker.sv */
// Port-level assertions for the line wrapper and their bind to the top level.
module dwlw_checker import dwlw_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_break_before,
   input logic [TAB_W-1:0]  rsp_unit_width,
   input logic [COL_W-1:0]  rsp_column_after
);

   // one unit in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while a unit is in work");

   // a new segment starts fresh with this unit's width
   a_break_column: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_break_before |->
         rsp_column_after == {{(COL_W-TAB_W){1'b0}}, rsp_unit_width})
      else $error("break without column restart");

   // a consumed trail unit never starts a segment
   a_skip_no_break: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_unit_width == '0) |-> !rsp_break_before)
      else $error("break on a consumed unit");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_column_after))
      else $error("result changed while stalled");

endmodule

bind display_width_line_wrapper dwlw_checker u_dwlw_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_break_before (rsp_break_before),
   .rsp_unit_width   (rsp_unit_width),
   .rsp_column_after (rsp_column_after)
);

/* bench/wrap_column_check.sv */
// Checker for the line wrapper: watches all ports, predicts each result and compares it.
module wrap_column_check import dwlw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [UNIT_W-1:0]     req_code_unit,
   input  logic                  req_last_unit,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_break_before,
   input  logic [TAB_W-1:0]      rsp_unit_width,
   input  logic [COL_W-1:0]      rsp_column_after,
   input  logic                  rsp_line_end,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    pending_results,
   output int                    units_checked,
   output int                    breaks_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned COLUMN_CEILING = 65535;

   typedef struct packed {
      logic              break_before;
      logic [TAB_W-1:0]  unit_width;
      logic [COL_W-1:0]  column_after;
      logic              line_end;
   } unit_layout_type;

   unit_layout_type   expected_layouts[$];
   logic [WRAP_W-1:0] wrap_cols;
   logic [TAB_W-1:0]  tab_cols;
   int unsigned       column;
   logic              trail_pending;

   function automatic int unsigned glyph_columns(input logic [UNIT_W-1:0] code);
      if (code inside {[16'hFF61:16'hFF9F]}) begin
         return 1;
      end
      if (code inside {[16'h1100:16'h115F], [16'h2E80:16'hA4CF], [16'hAC00:16'hD7A3],
                       [16'hF900:16'hFAFF], [16'hFF00:16'hFF60], [16'hFFE0:16'hFFE6],
                       [16'hD800:16'hDFFF]}) begin
         return 2;
      end
      return 1;
   endfunction

   // Advance the running column by one code unit and build the layout it produces.
   function automatic unit_layout_type place_unit(input logic [UNIT_W-1:0] code,
                                                  input logic is_last);
      unit_layout_type lay;
      int unsigned     cols;
      int unsigned     stop;
      lay = '0;
      if (trail_pending) begin
         trail_pending = 1'b0;
         cols = 0;
      end else begin
         if (code == CODE_TAB) begin
            stop = (tab_cols == '0) ? int'(TAB_DEFAULT) : int'(tab_cols);
            cols = stop - (column % stop);
         end else if (code inside {[16'hD800:16'hDBFF]} && !is_last) begin
            cols = 2;
            trail_pending = 1'b1;
         end else begin
            cols = glyph_columns(code);
         end
         if (wrap_cols != '0 && column > 0 && column + cols > wrap_cols) begin
            lay.break_before = 1'b1;
            column = 0;
         end
         column = column + cols;
         if (column > COLUMN_CEILING) begin
            column = COLUMN_CEILING;
         end
      end
      lay.unit_width   = cols[TAB_W-1:0];
      lay.column_after = column[COL_W-1:0];
      lay.line_end     = is_last;
      if (is_last) begin
         column = 0;
         trail_pending = 1'b0;
      end
      return lay;
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got,
                              inout bit bad);
      if (want != got) begin
         $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         bad = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      unit_layout_type want;
      bit              bad;
      if (reset) begin
         wrap_cols     = WRAP_RESET;
         tab_cols      = TAB_RESET;
         column        = 0;
         trail_pending = 1'b0;
         expected_layouts.delete();
         error_count   = 0;
         units_checked = 0;
         breaks_seen   = 0;
         pending_results <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_WRAP_COLUMNS: wrap_cols = csr_wdata[WRAP_W-1:0];
               CSR_TAB_COLUMNS:  tab_cols  = csr_wdata[TAB_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_layouts.insert(expected_layouts.size(),
                                    place_unit(req_code_unit, req_last_unit));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_layouts.size() == 0) begin
               $display({"[%0t] unexpected result: expected none, ",
                         "actual brk=%0d w=%0d col=%0d end=%0d"},
                        $time, rsp_break_before, rsp_unit_width, rsp_column_after,
                        rsp_line_end);
               error_count++;
            end else begin
               want = expected_layouts.pop_front();
               bad  = 1'b0;
               check_field("break_before", 32'(want.break_before), 32'(rsp_break_before),
                           bad);
               check_field("unit_width", 32'(want.unit_width), 32'(rsp_unit_width), bad);
               check_field("column_after", 32'(want.column_after), 32'(rsp_column_after),
                           bad);
               check_field("line_end", 32'(want.line_end), 32'(rsp_line_end), bad);
               if (bad) begin
                  error_count++;
               end
               if (want.break_before) begin
                  breaks_seen++;
               end
               units_checked++;
            end
         end
         pending_results <= expected_layouts.size();
      end
   end

endmodule

/* bench/tb_display_width_line_wrapper.sv */
// Testbench top for the line wrapper: clock, reset, stimulus, receiver and verdict.
module tb_display_width_line_wrapper import dwlw_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 150;
   localparam int PHASES      = 10;
   localparam int PHASE_UNITS = 35;

   localparam logic [16:0] DIRECTED_UNITS [25] = '{
      17'h00041, 17'h00009, 17'h00000, 17'h0FFFF, 17'h0FF61,
      17'h0FF9F, 17'h0FF60, 17'h0FFE0, 17'h0FFE6, 17'h0FFE7,
      17'h01100, 17'h0115F, 17'h02E80, 17'h0A4CF, 17'h0AC00,
      17'h0D7A3, 17'h0F900, 17'h0FAFF, 17'h0D800, 17'h0DC00,
      17'h0DBFF, 17'h00041, 17'h0DFFF, 17'h1DBFF, 17'h10009
   };

   localparam logic [UNIT_W-1:0] RANGE_BOUNDS [23] = '{
      16'h0000, 16'hFFFF, 16'h0008, 16'h000A, 16'h10FF, 16'h1160, 16'h2E7F, 16'hA4D0,
      16'hABFF, 16'hD7A4, 16'hF8FF, 16'hFB00, 16'hFEFF, 16'hFF60, 16'hFF61, 16'hFF9F,
      16'hFFA0, 16'hFFDF, 16'hFFE7, 16'hD7FF, 16'hE000, 16'hDBFF, 16'hDC00
   };

   localparam int unsigned WRAP_PLAN [7] = '{10, 0, 1, 1023, 80, 2, 37};
   localparam int unsigned TAB_PLAN  [7] = '{3, 0, 127, 64, 4, 1, 8};

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [UNIT_W-1:0]     req_code_unit;
   logic                  req_last_unit;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_break_before;
   logic [TAB_W-1:0]      rsp_unit_width;
   logic [COL_W-1:0]      rsp_column_after;
   logic                  rsp_line_end;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int error_count;
   int pending_results;
   int units_checked;
   int breaks_seen;
   int units_sent;
   int lines_sent;
   int settings_used;
   int results_taken;
   int send_idle_max;
   int recv_idle_max;
   int cycle_count = 0;

   display_width_line_wrapper dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_code_unit    (req_code_unit),
      .req_last_unit    (req_last_unit),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_break_before (rsp_break_before),
      .rsp_unit_width   (rsp_unit_width),
      .rsp_column_after (rsp_column_after),
      .rsp_line_end     (rsp_line_end),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   wrap_column_check u_wrap_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_code_unit    (req_code_unit),
      .req_last_unit    (req_last_unit),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_break_before (rsp_break_before),
      .rsp_unit_width   (rsp_unit_width),
      .rsp_column_after (rsp_column_after),
      .rsp_line_end     (rsp_line_end),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .pending_results  (pending_results),
      .units_checked    (units_checked),
      .breaks_seen      (breaks_seen)
   );

   initial begin
      clock = 1'b0;
   end

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_results);
         $display("TB_ERROR");
         $finish;
      end
   end

   // Offer one code unit after a random gap and hold it until the transfer.
   task automatic send_unit(input logic [UNIT_W-1:0] code, input bit is_last);
      int gap;
      gap = $urandom_range(0, send_idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_code_unit <= code;
      req_last_unit <= is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      units_sent++;
      if (is_last) begin
         lines_sent++;
      end
   endtask

   // Drain the block, then write both registers.
   task automatic set_layout(input int unsigned wrap_cols, input int unsigned tab_cols);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_WRAP_COLUMNS;
      csr_wdata <= CSR_DATA_W'(wrap_cols);
      @(posedge clock);
      csr_index <= CSR_TAB_COLUMNS;
      csr_wdata <= CSR_DATA_W'(tab_cols);
      @(posedge clock);
      csr_write <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [UNIT_W-1:0] pick_unit();
      case ($urandom_range(0, 9))
         0, 1: return CODE_TAB;
         2, 3: return UNIT_W'($urandom_range(16'h007E, 16'h0020));
         4:    return UNIT_W'($urandom_range(16'hFF9F, 16'hFF61));
         5: begin
            case ($urandom_range(0, 5))
               0:       return UNIT_W'($urandom_range(16'h115F, 16'h1100));
               1:       return UNIT_W'($urandom_range(16'hA4CF, 16'h2E80));
               2:       return UNIT_W'($urandom_range(16'hD7A3, 16'hAC00));
               3:       return UNIT_W'($urandom_range(16'hFAFF, 16'hF900));
               4:       return UNIT_W'($urandom_range(16'hFF60, 16'hFF00));
               default: return UNIT_W'($urandom_range(16'hFFE6, 16'hFFE0));
            endcase
         end
         6:       return UNIT_W'($urandom_range(16'hDBFF, 16'hD800));
         7:       return UNIT_W'($urandom_range(16'hDFFF, 16'hDC00));
         8:       return UNIT_W'($urandom());
         default: return RANGE_BOUNDS[$urandom_range(0, $size(RANGE_BOUNDS) - 1)];
      endcase
   endfunction

   // Mostly well-formed pairs; a lead is now and then followed by a stray unit.
   task automatic send_random_line(input int max_len);
      int                len;
      logic [UNIT_W-1:0] code;
      len = $urandom_range(1, max_len);
      for (int i = 0; i < len; i++) begin
         code = pick_unit();
         send_unit(code, i == len - 1);
         if (code inside {[16'hD800:16'hDBFF]} && i < len - 1 && $urandom_range(0, 7) != 0) begin
            i++;
            send_unit(UNIT_W'($urandom_range(16'hDFFF, 16'hDC00)), i == len - 1);
         end
      end
   endtask

   // Receiver: random stall per result, with a long hold-off now and then.
   initial begin
      rsp_ready     = 1'b0;
      results_taken = 0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         int idle;
         if (results_taken % 400 == 250) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            idle = $urandom_range(0, recv_idle_max);
            if (idle > 0) begin
               rsp_ready <= 1'b0;
               repeat (idle) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         results_taken++;
      end
   end

   initial begin
      int unsigned wrap_pick;
      int unsigned tab_pick;
      int          target;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_code_unit = '0;
      req_last_unit = 1'b0;
      csr_write     = 1'b0;
      csr_index     = CSR_WRAP_COLUMNS;
      csr_wdata     = '0;
      units_sent    = 0;
      lines_sent    = 0;
      settings_used = 1;
      send_idle_max = 6;
      recv_idle_max = 6;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_UNITS[i]) begin
         send_unit(DIRECTED_UNITS[i][15:0], DIRECTED_UNITS[i][16]);
      end

      // Push the column into saturation with wrapping off and the widest tab stops.
      set_layout(0, 127);
      repeat (530) send_unit(CODE_TAB, 1'b0);
      send_unit(16'h4E00, 1'b0);
      send_unit(CODE_TAB, 1'b0);
      send_unit(16'hD83D, 1'b0);
      send_unit(16'hDE00, 1'b0);
      send_unit(16'h0041, 1'b1);
      send_unit(CODE_TAB, 1'b1);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase < $size(WRAP_PLAN)) begin
            wrap_pick = WRAP_PLAN[phase];
            tab_pick  = TAB_PLAN[phase];
         end else begin
            wrap_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(1, 48);
            tab_pick  = $urandom_range(0, 127);
         end
         set_layout(wrap_pick, tab_pick);
         send_idle_max = (phase % 4 == 1) ? 0 : 6;
         recv_idle_max = (phase % 4 == 1) ? 0 : 6;
         target = units_sent + PHASE_UNITS;
         while (units_sent < target) begin
            send_random_line((phase % 3 == 0) ? 120 : 24);
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Run covered %0d code units in %0d lines under %0d register settings.",
               units_checked, lines_sent, settings_used);
      $display("Segment breaks checked: %0d; saturated column and stalled output exercised.",
               breaks_seen);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* display_width_line_wrapper.f */
hdl/dwlw_pkg.sv
hdl/dwlw_ctrl.sv
hdl/dwlw_dp.sv
hdl/display_width_line_wrapper.sv
hdl/dwlw_checker.sv
bench/wrap_column_check.sv
bench/tb_display_width_line_wrapper.sv
